### rtl/core/lkd_pkg.sv
// Package: key codes, commands, ladder thresholds and register indexes for the keypad decoder.
package lkd_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int NOW_W     = 32;
  localparam int CFG_W     = 16;
  localparam int KEY_W     = 3;
  localparam int CMD_W     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 8;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam key_t KEY_NONE   = 3'd0;
  localparam key_t KEY_ESC    = 3'd1;
  localparam key_t KEY_UP     = 3'd2;
  localparam key_t KEY_DOWN   = 3'd3;
  localparam key_t KEY_LEFT   = 3'd4;
  localparam key_t KEY_ENTER5 = 3'd5;

  localparam cmd_t CMD_ESCAPE = 3'd1;
  localparam cmd_t CMD_ENTER  = 3'd5;

  localparam cfg_idx_t REG_DEBOUNCE   = 8'd0;
  localparam cfg_idx_t REG_LONG_PRESS = 8'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd25;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  localparam logic [SAMPLE_W-1:0] THR_OPEN = 10'd1000;
  localparam logic [SAMPLE_W-1:0] THR_K1   = 10'd50;
  localparam logic [SAMPLE_W-1:0] THR_K2   = 10'd250;
  localparam logic [SAMPLE_W-1:0] THR_K3   = 10'd400;
  localparam logic [SAMPLE_W-1:0] THR_K4   = 10'd555;
  localparam logic [SAMPLE_W-1:0] THR_K5   = 10'd800;

  // Ladder voltage to key; above open threshold or in the gap is no key
  function automatic key_t decode_key(input logic [SAMPLE_W-1:0] s);
    key_t k;
    if (s > THR_OPEN)      k = KEY_NONE;
    else if (s < THR_K1)   k = KEY_ESC;
    else if (s < THR_K2)   k = KEY_UP;
    else if (s < THR_K3)   k = KEY_DOWN;
    else if (s < THR_K4)   k = KEY_LEFT;
    else if (s < THR_K5)   k = KEY_ENTER5;
    else                   k = KEY_NONE;
    return k;
  endfunction

endpackage

### rtl/core/ladder_keypad_debounce_longpress.sv
// Resistor-ladder keypad decoder: debounce, long press escape and auto-repeat.
// A sample passes through the input register and then the result register before its result beat.
// Throughput: one sample per cycle while the result stream is not stalled; the held-key state
// updates in the cycle a sample leaves the input register, so the next sample sees it directly.
// Reset (rst_n low, synchronous): both stages empty, held key none, change time zero,
// debounce 25 ms and long press 1000 ms.
module ladder_keypad_debounce_longpress #(
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lkd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lkd_pkg::CFG_W-1:0]         cfg_data,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lkd_pkg::IN_DATA_W-1:0]     in_tdata,   // [9:0] sample, [41:10] now_ms, zero pad
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lkd_pkg::OUT_DATA_W-1:0]    out_tdata   // [2:0] command, zero pad
);
  import lkd_pkg::*;

  logic [CFG_W-1:0]     debounce_r;
  logic [CFG_W-1:0]     long_press_r;

  logic                 s1_valid_r;
  logic [SAMPLE_W-1:0]  s1_sample_r;
  logic [NOW_W-1:0]     s1_now_r;

  logic [TIME_BITS-1:0] change_time_r, change_time_nxt;
  key_t                 held_key_r, held_key_nxt;
  logic                 lp_done_r, lp_done_nxt;

  logic                 out_valid_r;
  cmd_t                 out_cmd_r;

  logic                 out_free;
  logic                 advance;
  logic                 res_valid;
  cmd_t                 res_cmd;

  key_t                 key;
  logic [TIME_BITS-1:0] now_w;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] hold;
  logic                 outside_deb;
  logic                 changed;
  logic                 past_long;
  logic                 lp_base;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign advance    = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CMD_W){1'b0}}, out_cmd_r};

  always_comb begin
    key         = decode_key(s1_sample_r);
    now_w       = TIME_BITS'(s1_now_r);
    elapsed     = now_w - change_time_r;
    outside_deb = elapsed >= TIME_BITS'(debounce_r);
    changed     = outside_deb && (key != held_key_r);
    held_key_nxt    = outside_deb ? key : held_key_r;
    change_time_nxt = changed ? now_w : change_time_r;
    lp_base     = changed ? 1'b0 : lp_done_r;
    hold        = changed ? '0 : elapsed;
    past_long   = hold >= TIME_BITS'(long_press_r);
    lp_done_nxt = lp_base;
    res_valid   = 1'b0;
    res_cmd     = CMD_ESCAPE;
    if (held_key_nxt == KEY_ENTER5 && past_long && !lp_base) begin
      lp_done_nxt = 1'b1;
      res_valid   = 1'b1;
      res_cmd     = CMD_ESCAPE;
    end else if (!changed && !past_long) begin
      res_valid = 1'b0;
    end else if (held_key_nxt == KEY_ENTER5) begin
      // key 5 repeats nothing once the long press escape has gone out
      res_valid = !past_long;
      res_cmd   = CMD_ENTER;
    end else begin
      res_valid = 1'b1;
      res_cmd   = cmd_t'(held_key_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_data;
        REG_LONG_PRESS: long_press_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_sample_r <= in_tdata[SAMPLE_W-1:0];
      s1_now_r    <= in_tdata[SAMPLE_W +: NOW_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_time_r <= '0;
      held_key_r    <= KEY_NONE;
      lp_done_r     <= 1'b0;
    end else if (advance) begin
      change_time_r <= change_time_nxt;
      held_key_r    <= held_key_nxt;
      lp_done_r     <= lp_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_cmd_r <= res_cmd;
    end
  end

endmodule

### bench/keypad_cmd_checker.sv
`timescale 1ns / 100ps
// Keypad decoder checker: predicts commands from input beats and compares them with result beats.
module keypad_cmd_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [lkd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lkd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [lkd_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [lkd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output int                                 fail_count,
  output int                                 pending
);
  import lkd_pkg::*;

  cmd_t             cmd_expected[$];
  logic [CFG_W-1:0] debounce_win;
  logic [CFG_W-1:0] long_win;
  logic [NOW_W-1:0] stamp_ms;
  key_t             latched_key;
  logic             escape_sent;

  function automatic key_t ladder_key(input logic [SAMPLE_W-1:0] s);
    if (s > THR_OPEN) return KEY_NONE;
    if (s < THR_K1)   return KEY_ESC;
    if (s < THR_K2)   return KEY_UP;
    if (s < THR_K3)   return KEY_DOWN;
    if (s < THR_K4)   return KEY_LEFT;
    if (s < THR_K5)   return KEY_ENTER5;
    return KEY_NONE;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    key_t             k;
    logic [NOW_W-1:0] now_ms;
    logic [NOW_W-1:0] since;
    logic             moved;
    cmd_t             got;
    cmd_t             want;
    if (!rst_n) begin
      debounce_win = DEBOUNCE_RST;
      long_win     = LONG_PRESS_RST;
      stamp_ms     = '0;
      latched_key  = KEY_NONE;
      escape_sent  = 1'b0;
      cmd_expected.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[CMD_W-1:0];
        if (cmd_expected.size() == 0) begin
          $display("%0t: command beat with none expected, actual %0d", $time, got);
          fail_count++;
        end else begin
          want = cmd_expected.pop_front();
          if (got !== want) begin
            $display("%0t: command mismatch, expected %0d, actual %0d", $time, want, got);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:   debounce_win = cfg_data;
          REG_LONG_PRESS: long_win = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        k      = ladder_key(in_tdata[SAMPLE_W-1:0]);
        now_ms = in_tdata[SAMPLE_W +: NOW_W];
        moved  = 1'b0;
        since  = now_ms - stamp_ms;
        // inside the debounce window the held key stands
        if (since >= debounce_win) begin
          moved = (k != latched_key);
          latched_key = k;
          if (moved) begin
            stamp_ms = now_ms;
            escape_sent = 1'b0;
          end
        end
        since = now_ms - stamp_ms;
        if (latched_key == KEY_ENTER5 && since >= long_win && !escape_sent) begin
          escape_sent = 1'b1;
          cmd_expected.push_back(CMD_ESCAPE);
        end else if (moved || since >= long_win) begin
          if (latched_key != KEY_ENTER5)
            cmd_expected.push_back(cmd_t'(latched_key));
          else if (since < long_win)
            cmd_expected.push_back(CMD_ENTER);
        end
      end
    end
    pending = cmd_expected.size();
  end

endmodule

### bench/ladder_keypad_debounce_longpress_tb.sv
`timescale 1ns / 100ps
// Keypad decoder testbench top: clock, reset, register writes, sample stimulus and verdict.
module ladder_keypad_debounce_longpress_tb;
  import lkd_pkg::*;

  localparam cfg_idx_t REG_SPARE       = 8'd2;
  localparam cfg_idx_t REG_LAST        = 8'hFF;
  localparam int       SETTLE_CYCLES   = 6;
  localparam int       PHASES          = 7;
  localparam int       ITEMS_PER_PHASE = 104;
  localparam int       DIRECTED        = 24;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;

  int                    fail_count;
  int                    pending;
  logic                  idle_on    = 1'b1;
  int                    stall_left = 0;
  int                    cfg_db     = int'(DEBOUNCE_RST);
  int                    cfg_lp     = int'(LONG_PRESS_RST);
  logic [NOW_W-1:0]      clock_ms   = '0;

  // ladder bands; the top band covers the gap and the open reading, both no key
  logic [SAMPLE_W-1:0] band_lo [6] = '{'0, THR_K1, THR_K2, THR_K3, THR_K4, THR_K5};
  logic [SAMPLE_W-1:0] band_hi [6] =
    '{SAMPLE_W'(THR_K1 - 1), SAMPLE_W'(THR_K2 - 1), SAMPLE_W'(THR_K3 - 1),
      SAMPLE_W'(THR_K4 - 1), SAMPLE_W'(THR_K5 - 1), 10'h3FF};

  // threshold edges, debounce, long press escape, auto-repeat and time wrap
  logic [SAMPLE_W-1:0] dir_s [DIRECTED] = '{
    10'd1023, 10'd1001, 10'd1000, 10'd0,   10'd49,  10'd50,  10'd50,  10'd249,
    10'd250,  10'd399,  10'd400,  10'd554, 10'd555, 10'd799, 10'd799, 10'd600,
    10'd800,  10'd800,  10'd100,  10'd100, 10'd100, 10'd300, 10'd300, 10'd300};
  logic [NOW_W-1:0] dir_t [DIRECTED] = '{
    32'd100,  32'd130,  32'd200,  32'd300,  32'd310,  32'd320,  32'd330,  32'd360,
    32'd390,  32'd420,  32'd450,  32'd480,  32'd510,  32'd540,  32'd1510, 32'd1600,
    32'd1700, 32'd2700, 32'd2710, 32'd3710, 32'd3711, 32'hFFFF_FFF0, 32'h10, 32'h3E0};

  ladder_keypad_debounce_longpress DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  keypad_cmd_checker cmd_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [NOW_W-1:0] time_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 40) return NOW_W'($urandom_range(1, 20));
    if (r < 55) return NOW_W'(cfg_db + $urandom_range(0, 2) - 1);
    if (r < 70) return NOW_W'(cfg_lp + $urandom_range(0, 2) - 1);
    if (r < 97) return NOW_W'($urandom_range(0, cfg_lp / 4 + 1));
    return $urandom;
  endfunction

  function automatic logic [SAMPLE_W-1:0] band_sample(input int b);
    return SAMPLE_W'($urandom_range(band_lo[b], band_hi[b]));
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [NOW_W-1:0] t);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_DATA_W - SAMPLE_W - NOW_W){1'b0}}, t, s};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    // a sample with no command may still sit in the pipe
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input int db, input int lp);
    write_register(REG_DEBOUNCE, CFG_W'(db));
    write_register(REG_LONG_PRESS, CFG_W'(lp));
    cfg_db = db;
    cfg_lp = lp;
  endtask

  // mostly held keys with random timing, some bounce and arbitrary noise
  task automatic random_run(input int n);
    int sent;
    int b;
    int hold_len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 80) begin
        b = $urandom_range(0, 5);
        hold_len = $urandom_range(1, 12);
        repeat (hold_len) begin
          clock_ms = clock_ms + time_step();
          if ($urandom_range(0, 9) == 0)
            send_sample(SAMPLE_W'($urandom_range(0, 1023)), clock_ms);
          else
            send_sample(band_sample(b), clock_ms);
          sent++;
        end
      end else begin
        clock_ms = $urandom_range(0, 1) ? NOW_W'($urandom) : clock_ms + time_step();
        send_sample(SAMPLE_W'($urandom_range(0, 1023)), clock_ms);
        sent++;
      end
      if ($urandom_range(0, 99) == 0) wait_results_done();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED; i++)
      send_sample(dir_s[i], dir_t[i]);
    clock_ms = dir_t[DIRECTED-1];

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_results_done();
        case (p)
          1: set_config(0, 0);
          2: set_config(65535, 65535);
          3: begin
            set_config(0, 65535);
            write_register(REG_SPARE, CFG_W'($urandom));
            write_register(REG_LAST, 16'hFFFF);
          end
          4: set_config(65535, 0);
          5: set_config($urandom_range(1, 60), $urandom_range(50, 400));
          default: set_config($urandom_range(0, 65535), $urandom_range(0, 65535));
        endcase
      end
      idle_on = (p % 3 != 1);
      random_run(ITEMS_PER_PHASE);
    end

    wait_results_done();
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
